[rtl/core/ile_pkg.sv]
package ile_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [3:0] OP_APPEND  = 4'd0;
	localparam logic [3:0] OP_INSERT  = 4'd1;
	localparam logic [3:0] OP_GET     = 4'd2;
	localparam logic [3:0] OP_SET     = 4'd3;
	localparam logic [3:0] OP_RMAT    = 4'd4;
	localparam logic [3:0] OP_RMFIRST = 4'd5;
	localparam logic [3:0] OP_RMALL   = 4'd6;
	localparam logic [3:0] OP_INDEX   = 4'd7;
	localparam logic [3:0] OP_LAST    = 4'd8;
	localparam logic [3:0] OP_CLEAR   = 4'd9;
	localparam logic [3:0] OP_DEDUP   = 4'd10;
	localparam logic [3:0] OP_MOSTF   = 4'd11;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_RANGE = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_MISS  = 3'd4;

	// controller states, also seen by the cells as the current phase
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_APPEND  = 4'd1;
	localparam logic [3:0] PH_INSERT  = 4'd2;
	localparam logic [3:0] PH_ROTLOAD = 4'd3;
	localparam logic [3:0] PH_ROT     = 4'd4;
	localparam logic [3:0] PH_SCAN    = 4'd5;
	localparam logic [3:0] PH_COMMIT  = 4'd6;
	localparam logic [3:0] PH_COMPACT = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;

	typedef struct packed {
		logic [3:0] phase;
		logic [3:0] op;
		logic       par;
	} ctl_t;

endpackage

[rtl/core/ile_cell.sv]
module ile_cell #(
	parameter int CAPACITY   = ile_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF,
	parameter int CNT_W      = 7,
	parameter int PW         = 6,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ile_pkg::ctl_t         ctl,
	input  logic [CNT_W-1:0]      size,
	input  logic [5:0]            pos,
	input  logic [DATA_WIDTH-1:0] val,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  left_hole,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  right_hole,
	input  logic [DATA_WIDTH-1:0] rot_in,
	input  logic                  rotv_in,
	input  logic                  c_hit,
	input  logic [PW-1:0]         c_pos,
	input  logic [CNT_W-1:0]      c_cnt,
	input  logic [DATA_WIDTH-1:0] c_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  hole,
	output logic [DATA_WIDTH-1:0] rot,
	output logic                  rotv,
	output logic                  o_hit,
	output logic [PW-1:0]         o_pos,
	output logic [CNT_W-1:0]      o_cnt,
	output logic [DATA_WIDTH-1:0] o_data
);

	localparam logic ODD = logic'(INDEX % 2);

	logic [DATA_WIDTH-1:0] data_q, rot_q, o_data_q, n_data;
	logic                  hole_q, rotv_q, o_hit_q, n_hit;
	logic [PW-1:0]         o_pos_q, n_pos;
	logic [CNT_W-1:0]      fq_q, o_cnt_q, n_cnt;
	logic                  valid, at_pos, match, first, drop, mine;

	always_comb begin
		valid  = 32'(size) > INDEX;
		at_pos = 32'(pos) == INDEX;
		match  = valid && (data_q == val);
		first  = match && !c_hit;
		mine   = (ctl.par == ODD);
		n_hit  = c_hit;
		n_pos  = c_pos;
		n_cnt  = c_cnt;
		n_data = c_data;
		drop   = 1'b0;
		case (ctl.op)
			ile_pkg::OP_GET, ile_pkg::OP_SET, ile_pkg::OP_RMAT: begin
				n_hit = c_hit | at_pos;
				if (at_pos) n_data = data_q;
				drop = (ctl.op == ile_pkg::OP_RMAT) && at_pos;
			end
			ile_pkg::OP_RMFIRST, ile_pkg::OP_INDEX: begin
				n_hit = c_hit | match;
				if (first) n_pos = PW'(INDEX);
				drop = (ctl.op == ile_pkg::OP_RMFIRST) && first;
			end
			ile_pkg::OP_LAST: begin
				n_hit = c_hit | match;
				if (match) n_pos = PW'(INDEX);
			end
			ile_pkg::OP_RMALL: begin
				drop  = match;
				n_cnt = c_cnt + CNT_W'(match);
			end
			ile_pkg::OP_DEDUP: begin
				n_hit = c_hit | match;
				drop  = match && c_hit;
				n_cnt = c_cnt + CNT_W'(drop);
			end
			ile_pkg::OP_MOSTF: begin
				if (valid && fq_q > c_cnt) begin
					n_cnt  = fq_q;
					n_data = data_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		o_hit_q  <= n_hit;
		o_pos_q  <= n_pos;
		o_cnt_q  <= n_cnt;
		o_data_q <= n_data;
		case (ctl.phase)
			ile_pkg::PH_APPEND: begin
				if (32'(size) == INDEX) data_q <= val;
			end
			ile_pkg::PH_INSERT: begin
				if (at_pos) data_q <= val;
				else if (INDEX > 32'(pos) && INDEX <= 32'(size)) data_q <= left_data;
			end
			ile_pkg::PH_COMMIT: begin
				if (ctl.op == ile_pkg::OP_SET && at_pos) data_q <= val;
			end
			ile_pkg::PH_COMPACT: begin
				if (mine && hole_q && !right_hole) data_q <= right_data;
			end
			ile_pkg::PH_ROTLOAD: begin
				rot_q <= data_q;
			end
			ile_pkg::PH_ROT: begin
				rot_q <= rot_in;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= 1'b0;
			rotv_q <= 1'b0;
			fq_q   <= '0;
		end else begin
			case (ctl.phase)
				ile_pkg::PH_COMMIT: hole_q <= !valid || drop;
				ile_pkg::PH_COMPACT: begin
					if (mine && hole_q && !right_hole) hole_q <= 1'b0;
					else if (!mine && left_hole && !hole_q) hole_q <= 1'b1;
				end
				ile_pkg::PH_ROTLOAD: begin
					rotv_q <= valid;
					fq_q   <= '0;
				end
				ile_pkg::PH_ROT: begin
					rotv_q <= rotv_in;
					fq_q   <= fq_q + CNT_W'(rotv_q && valid && rot_q == data_q);
				end
				default: ;
			endcase
		end
	end

	assign data   = data_q;
	assign hole   = hole_q;
	assign rot    = rot_q;
	assign rotv   = rotv_q;
	assign o_hit  = o_hit_q;
	assign o_pos  = o_pos_q;
	assign o_cnt  = o_cnt_q;
	assign o_data = o_data_q;

endmodule

[rtl/core/indexed_list_engine.sv]
// Indexed list engine: an ordered list of words held in a row of cells.
// Requests arrive on s_tvalid/s_tready/s_tdata (opcode, position, value);
// each request yields one result on m_tvalid/m_tready/m_tdata.
// Path per request:
//   append, insert: one cell write (insert shifts the tail right)
//   clear, rejected requests, unused opcodes: straight to the result
//   get, set, index_of, last_index_of: one scan of the chain
//   remove_at, remove_first, remove_all, dedup_of: a scan, then compaction
//   most_frequent: a rotation of a copy of the list, then a scan
// Searches ripple one cell per cycle through the chain, removals close the
// gaps by odd-even swaps between neighbor cells, and the most frequent word
// needs a full rotation of a copy of the list.
// One request is worked at a time; s_tready is high only when idle.
// A finished result sits in the output register; if the receiver stalls, a
// newer result waits until the older one is taken.
// Reset empties the list; stored words are not cleared.
module indexed_list_engine #(
	parameter int CAPACITY   = ile_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // opcode[3:0], position_in[9:4], value_in[41:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // data_out[31:0], position_out[37:32], found[38],
	                              // count_out[45:39], status[48:46], size_now[55:49]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = $clog2(CAPACITY);
	localparam int CYC_W = $clog2(CAPACITY + 2);

	logic [3:0]            state_q, op_q;
	logic [5:0]            pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]      count_q;
	logic [CYC_W-1:0]      cyc_q;
	logic                  par_q;
	logic [2:0]            status_q;
	logic                  fin_hit_q;
	logic [PW-1:0]         fin_pos_q;
	logic [CNT_W-1:0]      fin_cnt_q;
	logic [DATA_WIDTH-1:0] fin_data_q;
	logic                  m_tvalid_q;
	logic [55:0]           m_tdata_q;
	ile_pkg::ctl_t         ctl;

	logic [DATA_WIDTH-1:0] data_a [CAPACITY];
	logic                  hole_a [CAPACITY];
	logic [DATA_WIDTH-1:0] rot_a  [CAPACITY];
	logic                  rotv_a [CAPACITY];
	logic                  hit_a  [CAPACITY];
	logic [PW-1:0]         cpos_a [CAPACITY];
	logic [CNT_W-1:0]      cnt_a  [CAPACITY];
	logic [DATA_WIDTH-1:0] cdat_a [CAPACITY];

	logic [3:0]  in_op;
	logic [5:0]  in_pos;
	logic        full, last_cyc;
	logic [31:0] r_data;
	logic [5:0]  r_pos;
	logic        r_found;
	logic [6:0]  r_cnt, r_size;

	assign in_op    = s_tdata[3:0];
	assign in_pos   = s_tdata[9:4];
	assign full     = 32'(count_q) >= CAPACITY;
	assign s_tready = (state_q == ile_pkg::PH_IDLE);
	assign ctl      = '{phase: state_q, op: op_q, par: par_q};

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] ld, rd, cd;
			logic                  lh, rh, ch;
			logic [PW-1:0]         cp;
			logic [CNT_W-1:0]      cc;
			if (gi == 0) begin : g_first
				assign ld = '0;
				assign lh = 1'b0;
				assign ch = 1'b0;
				assign cp = '0;
				assign cc = '0;
				assign cd = '0;
			end else begin : g_mid
				assign ld = data_a[gi-1];
				assign lh = hole_a[gi-1];
				assign ch = hit_a[gi-1];
				assign cp = cpos_a[gi-1];
				assign cc = cnt_a[gi-1];
				assign cd = cdat_a[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign rd = '0;
				assign rh = 1'b1;
			end else begin : g_nlast
				assign rd = data_a[gi+1];
				assign rh = hole_a[gi+1];
			end
			ile_cell #(
				.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH), .CNT_W(CNT_W),
				.PW(PW), .INDEX(gi)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl), .size(count_q),
				.pos(pos_q), .val(val_q),
				.left_data(ld), .left_hole(lh), .right_data(rd), .right_hole(rh),
				.rot_in(rot_a[(gi + 1) % CAPACITY]), .rotv_in(rotv_a[(gi + 1) % CAPACITY]),
				.c_hit(ch), .c_pos(cp), .c_cnt(cc), .c_data(cd),
				.data(data_a[gi]), .hole(hole_a[gi]), .rot(rot_a[gi]), .rotv(rotv_a[gi]),
				.o_hit(hit_a[gi]), .o_pos(cpos_a[gi]), .o_cnt(cnt_a[gi]), .o_data(cdat_a[gi])
			);
		end
	endgenerate

	assign last_cyc = (32'(cyc_q) == CAPACITY - 1);

	always_ff @(posedge clk) begin
		if (state_q == ile_pkg::PH_IDLE && s_tvalid) begin
			op_q      <= in_op;
			pos_q     <= in_pos;
			val_q     <= DATA_WIDTH'(s_tdata[41:10]);
			fin_hit_q <= 1'b0;
			fin_pos_q <= '0;
			fin_cnt_q <= '0;
			fin_data_q <= '0;
		end
		if (state_q == ile_pkg::PH_COMMIT) begin
			fin_hit_q  <= hit_a[CAPACITY-1];
			fin_pos_q  <= cpos_a[CAPACITY-1];
			fin_cnt_q  <= cnt_a[CAPACITY-1];
			fin_data_q <= cdat_a[CAPACITY-1];
		end
		if (state_q == ile_pkg::PH_DONE && (!m_tvalid_q || m_tready))
			m_tdata_q <= {r_size, status_q, r_cnt, r_found, r_pos, r_data};
	end

	always_comb begin
		r_data  = '0;
		r_pos   = '0;
		r_found = 1'b0;
		r_cnt   = '0;
		case (op_q)
			ile_pkg::OP_GET, ile_pkg::OP_SET, ile_pkg::OP_RMAT:
				r_data = 32'(fin_data_q);
			ile_pkg::OP_RMFIRST: begin
				r_found = fin_hit_q;
				if (fin_hit_q) r_data = 32'(val_q);
			end
			ile_pkg::OP_INDEX, ile_pkg::OP_LAST: begin
				r_found = fin_hit_q;
				if (fin_hit_q) r_pos = 6'(fin_pos_q);
			end
			ile_pkg::OP_RMALL, ile_pkg::OP_DEDUP:
				r_cnt = (32'(fin_cnt_q) > 127) ? 7'd127 : 7'(fin_cnt_q);
			ile_pkg::OP_MOSTF: begin
				r_data = 32'(fin_data_q);
				r_cnt  = (32'(fin_cnt_q) > 127) ? 7'd127 : 7'(fin_cnt_q);
			end
			default: ;
		endcase
		r_size = (32'(count_q) > 127) ? 7'd127 : 7'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ile_pkg::PH_IDLE;
			count_q    <= '0;
			cyc_q      <= '0;
			par_q      <= 1'b0;
			status_q   <= ile_pkg::ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			cyc_q <= cyc_q + 1'b1;
			par_q <= ~par_q;
			case (state_q)
				ile_pkg::PH_IDLE: begin
					cyc_q    <= '0;
					status_q <= ile_pkg::ST_OK;
					if (s_tvalid) begin
						state_q <= ile_pkg::PH_DONE;
						case (in_op)
							ile_pkg::OP_APPEND: begin
								if (full) status_q <= ile_pkg::ST_FULL;
								else state_q <= ile_pkg::PH_APPEND;
							end
							ile_pkg::OP_INSERT: begin
								if (32'(in_pos) > 32'(count_q)) status_q <= ile_pkg::ST_RANGE;
								else if (full) status_q <= ile_pkg::ST_FULL;
								else state_q <= ile_pkg::PH_INSERT;
							end
							ile_pkg::OP_GET, ile_pkg::OP_SET, ile_pkg::OP_RMAT: begin
								if (32'(in_pos) >= 32'(count_q)) status_q <= ile_pkg::ST_RANGE;
								else state_q <= ile_pkg::PH_SCAN;
							end
							ile_pkg::OP_RMFIRST, ile_pkg::OP_RMALL, ile_pkg::OP_INDEX,
							ile_pkg::OP_LAST, ile_pkg::OP_DEDUP:
								state_q <= ile_pkg::PH_SCAN;
							ile_pkg::OP_CLEAR: count_q <= '0;
							ile_pkg::OP_MOSTF: begin
								if (count_q == '0) status_q <= ile_pkg::ST_EMPTY;
								else state_q <= ile_pkg::PH_ROTLOAD;
							end
							default: ;
						endcase
					end
				end
				ile_pkg::PH_APPEND, ile_pkg::PH_INSERT: begin
					count_q <= count_q + 1'b1;
					state_q <= ile_pkg::PH_DONE;
				end
				ile_pkg::PH_ROTLOAD: begin
					cyc_q   <= '0;
					state_q <= ile_pkg::PH_ROT;
				end
				ile_pkg::PH_ROT: begin
					if (last_cyc) begin
						cyc_q   <= '0;
						state_q <= ile_pkg::PH_SCAN;
					end
				end
				ile_pkg::PH_SCAN: begin
					if (last_cyc) state_q <= ile_pkg::PH_COMMIT;
				end
				ile_pkg::PH_COMMIT: begin
					cyc_q   <= '0;
					state_q <= ile_pkg::PH_DONE;
					case (op_q)
						ile_pkg::OP_RMAT: begin
							count_q <= count_q - 1'b1;
							state_q <= ile_pkg::PH_COMPACT;
						end
						ile_pkg::OP_RMFIRST: begin
							count_q <= count_q - CNT_W'(hit_a[CAPACITY-1]);
							state_q <= ile_pkg::PH_COMPACT;
						end
						ile_pkg::OP_RMALL, ile_pkg::OP_DEDUP: begin
							count_q <= count_q - cnt_a[CAPACITY-1];
							state_q <= ile_pkg::PH_COMPACT;
						end
						default: ;
					endcase
					if ((op_q == ile_pkg::OP_RMFIRST || op_q == ile_pkg::OP_INDEX ||
					     op_q == ile_pkg::OP_LAST) && !hit_a[CAPACITY-1])
						status_q <= ile_pkg::ST_MISS;
				end
				ile_pkg::PH_COMPACT: begin
					if (32'(cyc_q) == CAPACITY) state_q <= ile_pkg::PH_DONE;
				end
				ile_pkg::PH_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ile_pkg::PH_IDLE;
					end
				end
				default: state_q <= ile_pkg::PH_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("list size above capacity");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ile_pkg::PH_DONE))
		else $error("result raised outside completion");

	a_compact_size: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ile_pkg::PH_COMPACT && $past(state_q == ile_pkg::PH_COMPACT)
		|-> $stable(count_q))
		else $error("size changed during compaction");

endmodule
